### rtl/pcf_pkg.sv
package pcf_pkg;

   // Command codes on the request channel
   localparam logic [1:0] CMD_SIG  = 2'd0;
   localparam logic [1:0] CMD_HDR  = 2'd1;
   localparam logic [1:0] CMD_DATA = 2'd2;

   // Job kinds handed from the front end to the serializer
   localparam int          KIND_W         = 3;
   localparam logic [2:0]  KIND_SIG       = 3'd0;
   localparam logic [2:0]  KIND_HDR_OPEN  = 3'd1;
   localparam logic [2:0]  KIND_HDR_CLOSE = 3'd2;
   localparam logic [2:0]  KIND_DATA      = 3'd3;
   localparam logic [2:0]  KIND_DATA_END  = 3'd4;
   localparam logic [2:0]  KIND_ERR       = 3'd5;

   // Final step index of each job kind (one output byte per step)
   localparam int          STEP_W             = 4;
   localparam logic [3:0]  STEP_LAST_SIG      = 4'd7;
   localparam logic [3:0]  STEP_LAST_HDR_OPEN = 4'd7;
   localparam logic [3:0]  STEP_LAST_HDR_CLOSE = 4'd11;
   localparam logic [3:0]  STEP_LAST_DATA_END = 4'd4;
   localparam logic [3:0]  STEP_FIRST         = 4'd0;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
   localparam logic [7:0]  ERR_BYTE = 8'h00;

   // Job queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [1:0]  cmd;
      logic [30:0] chunk_length;
      logic [31:0] chunk_type;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       err;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [30:0] chunk_length;
      logic [31:0] chunk_type;
      logic [7:0]  data_byte;
   } job_type;

   // Fold one byte into a reflected CRC-32
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = CRC_POLY ^ (c >> 1);
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // Pick byte idx of a word, most significant first
   function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0:    b = w[31:24];
         2'd1:    b = w[23:16];
         2'd2:    b = w[15:8];
         default: b = w[7:0];
      endcase
      return b;
   endfunction

   // Standard PNG file signature
   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0:    b = 8'd137;
         3'd1:    b = 8'd80;
         3'd2:    b = 8'd78;
         3'd3:    b = 8'd71;
         3'd4:    b = 8'd13;
         3'd5:    b = 8'd10;
         3'd6:    b = 8'd26;
         default: b = 8'd10;
      endcase
      return b;
   endfunction

endpackage

### rtl/png_chunk_crc_framer.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    pcf_pkg::req_type (cmd, length, type, byte)
// rsp       out        rsp_valid/rsp_ready    pcf_pkg::rsp_type (out_byte, last, err)
//
// One output byte leaves per cycle unless rsp_ready stalls or no job waits; pcf_back sets the rate.
// A data transaction yields 1 byte, a signature 8, a header 8 (or 12 when its
// length is zero), the closing data byte 5 (byte plus four CRC bytes).
// Reset is synchronous and clears framing state, CRC and queue; no clear pass.
// A two-entry job queue takes up to two more transactions while rsp stalls;
// the serializer holds while a byte waits in its output register for rsp_ready.
module png_chunk_crc_framer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pcf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pcf_pkg::rsp_type rsp_data
);

   logic             job_push;
   logic             job_pop;
   logic             job_valid;
   pcf_pkg::job_type push_job;
   pcf_pkg::job_type head_job;

   // Front end: classify commands, track chunk framing and byte count
   pcf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_push  (job_push),
      .job       (push_job)
   );

   // Decouple classification from serialization
   pcf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (push_job),
      .not_full  (req_ready),
      .pop       (job_pop),
      .not_empty (job_valid),
      .head_job  (head_job)
   );

   // Back end: emit bytes, fold CRC, append CRC at chunk close
   pcf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .head_job  (head_job),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/pcf_front.sv
module pcf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  pcf_pkg::req_type req_data,
   output logic             job_push,
   output pcf_pkg::job_type job
);

   logic        chunk_open_ff, chunk_open_in;
   logic [30:0] bytes_left_ff, bytes_left_in;
   logic [30:0] bytes_dec;

   assign job_push  = req_valid && req_ready;
   assign bytes_dec = bytes_left_ff - 31'd1;

   // Classify the command against the chunk framing state
   always_comb begin
      chunk_open_in    = chunk_open_ff;
      bytes_left_in    = bytes_left_ff;
      job.kind         = pcf_pkg::KIND_ERR;
      job.chunk_length = req_data.chunk_length;
      job.chunk_type   = req_data.chunk_type;
      job.data_byte    = req_data.data_byte;
      priority if (req_data.cmd == pcf_pkg::CMD_SIG && !chunk_open_ff) begin
         job.kind = pcf_pkg::KIND_SIG;
      end else if (req_data.cmd == pcf_pkg::CMD_HDR && !chunk_open_ff) begin
         if (req_data.chunk_length == 31'd0) begin
            job.kind = pcf_pkg::KIND_HDR_CLOSE;
         end else begin
            job.kind      = pcf_pkg::KIND_HDR_OPEN;
            chunk_open_in = 1'b1;
            bytes_left_in = req_data.chunk_length;
         end
      end else if (req_data.cmd == pcf_pkg::CMD_DATA && chunk_open_ff) begin
         bytes_left_in = bytes_dec;
         if (bytes_dec == 31'd0) begin
            job.kind      = pcf_pkg::KIND_DATA_END;
            chunk_open_in = 1'b0;
         end else begin
            job.kind = pcf_pkg::KIND_DATA;
         end
      end else begin
         job.kind = pcf_pkg::KIND_ERR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_open_ff <= 1'b0;
         bytes_left_ff <= '0;
      end else if (job_push) begin
         chunk_open_ff <= chunk_open_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule

### rtl/pcf_queue.sv
module pcf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pcf_pkg::job_type push_job,
   output logic             not_full,
   input  logic             pop,
   output logic             not_empty,
   output pcf_pkg::job_type head_job
);

   pcf_pkg::job_type                  mem_ff [pcf_pkg::QDEPTH];
   logic [pcf_pkg::QPTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [pcf_pkg::QCNT_W-1:0]        count_ff;

   assign not_full  = count_ff != pcf_pkg::QCNT_W'(pcf_pkg::QDEPTH);
   assign not_empty = count_ff != '0;
   assign head_job  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + pcf_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + pcf_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + pcf_pkg::QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - pcf_pkg::QCNT_W'(1);
         end
      end
   end

endmodule

### rtl/pcf_back.sv
module pcf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  pcf_pkg::job_type head_job,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pcf_pkg::rsp_type rsp_data
);

   logic                        busy_ff, busy_in;
   logic [pcf_pkg::STEP_W-1:0]  step_ff, step_in;
   pcf_pkg::job_type            hold_ff;
   logic [31:0]                 crc_ff, crc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   pcf_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   pcf_pkg::job_type            cur;
   logic [pcf_pkg::STEP_W-1:0]  step;
   logic [pcf_pkg::STEP_W-1:0]  step_m1;
   logic [31:0]                 crc_final;
   logic                        adv;
   logic                        final_step;
   logic                        fold;
   logic                        close;
   logic [7:0]                  byte_val;

   assign cur       = busy_ff ? hold_ff : head_job;
   assign step      = busy_ff ? step_ff : pcf_pkg::STEP_FIRST;
   assign step_m1   = step - pcf_pkg::STEP_W'(1);
   assign crc_final = crc_ff ^ pcf_pkg::CRC_INIT;
   assign adv       = (busy_ff || job_valid) && (!rsp_valid_ff || rsp_ready);
   assign job_pop   = adv && !busy_ff;

   // Byte, fold and close decode for the current job step
   always_comb begin
      byte_val   = pcf_pkg::ERR_BYTE;
      final_step = 1'b1;
      fold       = 1'b0;
      close      = 1'b0;
      unique case (cur.kind)
         pcf_pkg::KIND_SIG: begin
            byte_val   = pcf_pkg::sig_byte(step[2:0]);
            final_step = step == pcf_pkg::STEP_LAST_SIG;
         end
         pcf_pkg::KIND_HDR_OPEN, pcf_pkg::KIND_HDR_CLOSE: begin
            if (step[3:2] == 2'd0) begin
               byte_val = pcf_pkg::word_byte({1'b0, cur.chunk_length}, step[1:0]);
            end else if (step[3:2] == 2'd1) begin
               byte_val = pcf_pkg::word_byte(cur.chunk_type, step[1:0]);
               fold     = 1'b1;
            end else begin
               byte_val = pcf_pkg::word_byte(crc_final, step[1:0]);
            end
            if (cur.kind == pcf_pkg::KIND_HDR_OPEN) begin
               final_step = step == pcf_pkg::STEP_LAST_HDR_OPEN;
            end else begin
               final_step = step == pcf_pkg::STEP_LAST_HDR_CLOSE;
               close      = final_step;
            end
         end
         pcf_pkg::KIND_DATA: begin
            byte_val   = cur.data_byte;
            fold       = 1'b1;
            final_step = 1'b1;
         end
         pcf_pkg::KIND_DATA_END: begin
            if (step == pcf_pkg::STEP_FIRST) begin
               byte_val = cur.data_byte;
               fold     = 1'b1;
            end else begin
               byte_val = pcf_pkg::word_byte(crc_final, step_m1[1:0]);
            end
            final_step = step == pcf_pkg::STEP_LAST_DATA_END;
            close      = final_step;
         end
         default: begin
            byte_val   = pcf_pkg::ERR_BYTE;
            final_step = 1'b1;
         end
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (adv) begin
         busy_in           = !final_step;
         step_in           = step + pcf_pkg::STEP_W'(1);
         rsp_valid_in      = 1'b1;
         rsp_data_in.out_byte = byte_val;
         rsp_data_in.last  = final_step;
         rsp_data_in.err   = cur.kind == pcf_pkg::KIND_ERR;
         if (close) begin
            crc_in = pcf_pkg::CRC_INIT;
         end else if (fold) begin
            crc_in = pcf_pkg::crc_byte(crc_ff, byte_val);
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         crc_ff       <= pcf_pkg::CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         hold_ff <= head_job;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
